// ----- rtl/array_bst_insert_find_core_defines.svh -----
// Assertion helpers shared by the tree core.
// All of them sample on clk_i and are switched off while rst_ni is low.
`ifndef ARRAY_BST_INSERT_FIND_CORE_DEFINES_SVH
`define ARRAY_BST_INSERT_FIND_CORE_DEFINES_SVH

// A condition that must hold at every clock edge.
`define ABIF_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define ABIF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define ABIF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/abif_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package abif_pkg;

  // Field widths of the request and result.
  localparam int KEY_W    = 32;
  localparam int SLOT_W   = 7;
  localparam int STATUS_W = 2;

  // Request kinds.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_FIND   = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd3;

  typedef struct packed {
    logic             req_type;
    logic [KEY_W-1:0] key;
  } abif_req_t;

  typedef struct packed {
    logic                found;
    logic [SLOT_W-1:0]   slot;
    logic [STATUS_W-1:0] status;
  } abif_res_t;

endpackage

`default_nettype wire

// ----- rtl/array_bst_insert_find_core.sv -----
// Results: a zero-key request gives its result in the cycle after it is accepted; any other
// request gives it after a walk over L levels of the tree, L at most floor(log2(TREE_SLOTS))+1,
// with one node memory read per level.
// Throughput: one request at a time; the next one may be accepted in the result cycle.
// Reset: a clearing pass writes zero to slots 1..TREE_SLOTS, one per cycle, with busy_o
// high. Results are not back-pressured by the receiver.
`timescale 1ns / 1ps
`default_nettype none

`include "array_bst_insert_find_core_defines.svh"

module array_bst_insert_find_core
  import abif_pkg::*;
#(
  parameter int TREE_SLOTS = 127
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire abif_req_t req_i,
  output logic           busy_o,
  output logic           done_o,
  output abif_res_t      res_o
);

  localparam int ADDR_W = $clog2(TREE_SLOTS + 1);
  localparam int POS_W  = ADDR_W + 1;

  localparam logic [POS_W-1:0]  ROOT_POS  = POS_W'(1);
  localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(TREE_SLOTS);
  localparam logic [ADDR_W-1:0] FIRST_CLR = ADDR_W'(1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TREE_SLOTS);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK
  } state_e;

  state_e            state_q, state_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic              type_q, type_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic              done_q, done_d;
  abif_res_t         res_q, res_d;

  // Node memory and its port signals.
  logic [KEY_W-1:0]  mem_q [0:TREE_SLOTS];
  logic [KEY_W-1:0]  rd_data_q;
  logic              mem_re;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_raddr;
  logic [ADDR_W-1:0] mem_waddr;
  logic [KEY_W-1:0]  mem_wdata;

  // Compare results for the node read in the previous cycle.
  logic                    node_empty;
  logic                    node_hit;
  logic                    go_right;
  logic [POS_W-1:0]        next_pos;
  logic                    off_end;
  logic [POS_W+SLOT_W-1:0] pos_ext;
  logic [SLOT_W-1:0]       cur_slot;

  assign node_empty = (rd_data_q == '0);
  assign node_hit   = (rd_data_q == key_q);
  assign go_right   = (key_q > rd_data_q);
  assign next_pos   = {pos_q[POS_W-2:0], go_right};
  assign off_end    = (next_pos > LAST_POS);
  assign pos_ext    = {{SLOT_W{1'b0}}, pos_q};
  assign cur_slot   = pos_ext[SLOT_W-1:0];

  // Next-state logic: clear sweep, accept, then one tree level per cycle.
  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    key_d     = key_q;
    type_d    = type_q;
    clr_d     = clr_q;
    done_d    = 1'b0;
    res_d     = res_q;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = pos_q[ADDR_W-1:0];
    mem_wdata = key_q;

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        if (clr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + FIRST_CLR;
        end
      end

      ST_IDLE: begin
        if (start_i) begin
          if (req_i.key == '0) begin
            done_d = 1'b1;
            res_d  = '{found: 1'b0, slot: '0, status: STATUS_ZERO};
          end else begin
            key_d   = req_i.key;
            type_d  = req_i.req_type;
            pos_d   = ROOT_POS;
            mem_re  = 1'b1;
            state_d = ST_WALK;
          end
        end
      end

      ST_WALK: begin
        if (node_empty) begin
          // First empty slot on the path: place the key or report a miss.
          done_d  = 1'b1;
          state_d = ST_IDLE;
          if (type_q == REQ_INSERT) begin
            mem_we = 1'b1;
            res_d  = '{found: 1'b1, slot: cur_slot, status: STATUS_OK};
          end else begin
            res_d  = '{found: 1'b0, slot: '0, status: STATUS_MISS};
          end
        end else if (node_hit) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
          if (type_q == REQ_INSERT) begin
            res_d = '{found: 1'b0, slot: '0, status: STATUS_MISS};
          end else begin
            res_d = '{found: 1'b1, slot: cur_slot, status: STATUS_OK};
          end
        end else if (off_end) begin
          // The path leaves the array before reaching an empty slot.
          done_d  = 1'b1;
          state_d = ST_IDLE;
          if (type_q == REQ_INSERT) begin
            res_d = '{found: 1'b0, slot: '0, status: STATUS_FULL};
          end else begin
            res_d = '{found: 1'b0, slot: '0, status: STATUS_MISS};
          end
        end else begin
          pos_d  = next_pos;
          mem_re = 1'b1;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign mem_raddr = pos_d[ADDR_W-1:0];

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      pos_q   <= ROOT_POS;
      key_q   <= '0;
      type_q  <= REQ_INSERT;
      clr_q   <= FIRST_CLR;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      key_q   <= key_d;
      type_q  <= type_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
      res_q   <= res_d;
    end
  end

  // Node memory: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  // The walk only ever visits slots inside the array.
  `ABIF_ASSERT_IMP(a_walk_in_range, state_q == ST_WALK, (pos_q != '0) && (pos_q <= LAST_POS), "walk position outside the array")
  // A result is only delivered while the core is ready for the next request.
  `ABIF_ASSERT_IMP(a_done_idle, done_o, !busy_o, "result strobe while busy")
  // An accepted request either starts a walk or answers at once.
  `ABIF_ASSERT_NEXT(a_accept_progress, start_i && !busy_o, busy_o || done_o, "accepted request dropped")
  // For trees of up to 127 slots, success carries an ok status and a nonzero slot number.
  `ABIF_ASSERT_IMP(a_found_ok, done_o && res_o.found, (res_o.status == STATUS_OK) && (res_o.slot != '0) || (TREE_SLOTS > 127), "found result with bad status")
  // Failures report slot zero.
  `ABIF_ASSERT_IMP(a_fail_slot, done_o && !res_o.found, (res_o.slot == '0) && (res_o.status != STATUS_OK), "failed result with a slot")

endmodule

`default_nettype wire

// ----- sim/tb_array_bst_insert_find_core.sv -----
`timescale 1ns / 1ps

module tb_array_bst_insert_find_core;
  import abif_pkg::*;

  localparam int NUM_SLOTS  = 127;
  localparam int IDLE_LIMIT = 4000;

  logic      clk_i;
  logic      rst_ni;
  logic      start_i;
  abif_req_t req_i;
  logic      busy_o;
  logic      done_o;
  abif_res_t res_o;

  // Shadow copy of the tree store; slot 0 is never used.
  logic [KEY_W-1:0] tree_keys [0:NUM_SLOTS];
  logic [KEY_W-1:0] stored_keys[$];
  abif_res_t        pending_results[$];

  int error_count;
  int insert_count;
  int find_count;
  int status_seen [4];
  int highest_slot;
  int idle_run;

  array_bst_insert_find_core #(
    .TREE_SLOTS(NUM_SLOTS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always #1 clk_i = ~clk_i;

  // Walk the shadow tree for one request and update it on a successful insert.
  function automatic abif_res_t tree_walk(input abif_req_t rq);
    abif_res_t rs;
    int        pos;
    rs     = '0;
    pos    = 1;
    if (rq.key == '0) begin
      rs.status = STATUS_ZERO;
      return rs;
    end
    while (pos <= NUM_SLOTS && tree_keys[pos] != '0) begin
      if (rq.key == tree_keys[pos]) begin
        if (rq.req_type == REQ_FIND) begin
          rs.found  = 1'b1;
          rs.slot   = SLOT_W'(pos);
          rs.status = STATUS_OK;
        end else begin
          rs.status = STATUS_MISS;
        end
        return rs;
      end
      pos = (rq.key < tree_keys[pos]) ? 2 * pos : 2 * pos + 1;
    end
    if (rq.req_type == REQ_FIND) begin
      rs.status = STATUS_MISS;
    end else if (pos > NUM_SLOTS) begin
      rs.status = STATUS_FULL;
    end else begin
      tree_keys[pos] = rq.key;
      stored_keys.push_back(rq.key);
      if (pos > highest_slot) highest_slot = pos;
      rs.found  = 1'b1;
      rs.slot   = SLOT_W'(pos);
      rs.status = STATUS_OK;
    end
    return rs;
  endfunction

  // Pick a key that lands in an empty slot: descend at random while tracking the
  // open interval of keys that would follow the same path.
  function automatic logic [KEY_W-1:0] fitting_key();
    longint lo;
    longint hi;
    int     pos;
    lo  = 0;
    hi  = 64'h1_0000_0000;
    pos = 1;
    while (pos <= NUM_SLOTS && tree_keys[pos] != '0) begin
      if ($urandom_range(1) == 0) begin
        hi  = tree_keys[pos];
        pos = 2 * pos;
      end else begin
        lo  = tree_keys[pos];
        pos = 2 * pos + 1;
      end
    end
    if (pos > NUM_SLOTS || hi - lo < 2) return $urandom_range(32'hFFFF_FFFF, 1);
    return $urandom_range(32'(hi - 1), 32'(lo + 1));
  endfunction

  // Present one request from a falling edge and hold it until the core takes it.
  task automatic issue_request(input logic kind, input logic [KEY_W-1:0] key);
    logic taken;
    taken       = 1'b0;
    start_i     = 1'b1;
    req_i.req_type = kind;
    req_i.key      = key;
    while (!taken) begin
      @(posedge clk_i);
      if (!busy_o) begin
        taken = 1'b1;
        pending_results.push_back(tree_walk(req_i));
        if (kind == REQ_INSERT) insert_count++;
        else find_count++;
      end
      @(negedge clk_i);
    end
  endtask

  task automatic pause_cycles(input int n);
    start_i = 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // Hold the sender off until every outstanding result has come back.
  task automatic wait_drained();
    start_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_zero_key();
    issue_request(REQ_INSERT, '0);
    issue_request(REQ_FIND, '0);
  endtask

  task automatic test_insert_and_find();
    issue_request(REQ_INSERT, 32'h8000_0000);
    issue_request(REQ_INSERT, 32'hFFFF_FFFF);
    issue_request(REQ_FIND, 32'hFFFF_FFFF);
    issue_request(REQ_FIND, 32'h8000_0000);
  endtask

  task automatic test_duplicate();
    issue_request(REQ_INSERT, 32'h8000_0000);
    issue_request(REQ_INSERT, 32'hFFFF_FFFF);
  endtask

  // Build the left spine down to the last level, then push one key past it.
  task automatic test_no_room();
    logic [KEY_W-1:0] k;
    k = 32'h4000_0000;
    repeat (6) begin
      issue_request(REQ_INSERT, k);
      k = k >> 1;
    end
    issue_request(REQ_INSERT, 32'h0000_0001);
  endtask

  // Misses that stop at the array bottom and at empty slots on either side.
  task automatic test_absent();
    issue_request(REQ_FIND, 32'h0000_0001);
    issue_request(REQ_FIND, 32'h7FFF_FFFF);
    issue_request(REQ_FIND, 32'hFFFF_FFFE);
  endtask

  // Mostly inserts that fit and finds of stored keys, with some noise mixed in.
  task automatic test_random_mix(input int n_items, input int idle_pct);
    int               pick;
    logic [KEY_W-1:0] key;
    logic             kind;
    repeat (n_items) begin
      // Each cycle in which a request could be presented is skipped at the given rate.
      while ($urandom_range(99) < idle_pct) pause_cycles(1);
      pick = $urandom_range(99);
      if (pick < 3) begin
        kind = 1'($urandom_range(1));
        key  = '0;
      end else if (pick < 40) begin
        kind = REQ_INSERT;
        key  = fitting_key();
      end else if (pick < 50) begin
        kind = REQ_INSERT;
        key  = $urandom();
      end else if (pick < 55 && stored_keys.size() != 0) begin
        kind = REQ_INSERT;
        key  = stored_keys[$urandom_range(stored_keys.size() - 1)];
      end else if (pick < 85 && stored_keys.size() != 0) begin
        kind = REQ_FIND;
        key  = stored_keys[$urandom_range(stored_keys.size() - 1)];
      end else begin
        kind = REQ_FIND;
        key  = $urandom();
      end
      issue_request(kind, key);
    end
  endtask

  // Compare each result strobe with the oldest prediction.
  always @(posedge clk_i) begin
    abif_res_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing outstanding: found=%0d slot=%0d status=%0d",
               res_o.found, res_o.slot, res_o.status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        status_seen[want.status]++;
        if (res_o.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, res_o.found);
          error_count++;
        end
        if (res_o.slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, res_o.slot);
          error_count++;
        end
        if (res_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_o.status);
          error_count++;
        end
      end
    end
  end

  // End the run if nothing moves across either side for too long.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o && rst_ni) || (rst_ni && done_o)) begin
      idle_run <= 0;
    end else if (idle_run >= IDLE_LIMIT) begin
      $display("tb_array_bst_insert_find_core failed");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    req_i        = '0;
    error_count  = 0;
    insert_count = 0;
    find_count   = 0;
    highest_slot = 0;
    idle_run     = 0;
    status_seen  = '{default: 0};
    for (int i = 0; i <= NUM_SLOTS; i++) tree_keys[i] = '0;

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    test_zero_key();
    test_insert_and_find();
    test_duplicate();
    test_no_room();
    test_absent();
    wait_drained();

    test_random_mix(545, 16);
    wait_drained();
    test_random_mix(545, 59);
    wait_drained();
    test_random_mix(545, 0);
    wait_drained();
    repeat (20) @(negedge clk_i);

    $display("Sent %0d inserts and %0d finds; deepest slot filled was %0d.",
             insert_count, find_count, highest_slot);
    $display("Results by status: %0d ok, %0d duplicate or absent, %0d no room, %0d zero key.",
             status_seen[STATUS_OK], status_seen[STATUS_MISS],
             status_seen[STATUS_FULL], status_seen[STATUS_ZERO]);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb_array_bst_insert_find_core passed");
    end else begin
      $display("tb_array_bst_insert_find_core failed");
    end
    $finish;
  end

endmodule
